[sv/bbc_pkg.sv]
package bbc_pkg;

	// Number of buffer slots and the width of a slot index.
	localparam int SLOT_COUNT = 32;
	localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Largest reference count a slot can hold.
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	typedef logic [SLOT_IW-1:0] slot_idx_t;

	typedef enum logic [1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFREE = 2'd1,
		ST_UNDER  = 2'd2,
		ST_OVER   = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEL,
		S_UPD
	} state_e;

	typedef struct packed {
		cmd_e        cmd;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [4:0]  slot_in;
	} req_t;

	typedef struct packed {
		logic [4:0] slot_out;
		logic       hit;
		logic       need_read;
		status_e    status;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic select;
		logic commit;
	} ctrl_cmd_t;

endpackage

[sv/block_buffer_cache_lru_refcount_top.sv]
// Tag and replacement engine for a disk-block buffer cache of 32 slots.
// A request is accepted; in the next cycle, every slot's tag is
// compared at once and the most recent matching slot and the least recent
// free slot are picked from a recency matrix; in the update step that
// follows, the chosen slot's count, valid bit and tag are updated and the
// response is loaded into the output register. A new request can be taken
// in the cycle the previous one updates, but not while it selects, since
// the select then update sequence runs on the shared slot state. A waiting
// response holds the update step and, with it, the acceptance of the next
// request. After reset every slot is tagged device 0, block 0, with count
// zero and invalid, and the highest slot is the most recent.
module block_buffer_cache_lru_refcount_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bbc_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bbc_pkg::rsp_t  rsp
);

	bbc_pkg::ctrl_cmd_t cmd;

	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	bbc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[sv/bbc_ctrl.sv]
module bbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bbc_pkg::ctrl_cmd_t  cmd
);

	bbc_pkg::state_e state_q, state_d;
	logic            rsp_valid_q;
	logic            out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		cmd.select  = 1'b0;
		cmd.commit  = 1'b0;
		req_stall   = 1'b1;
		case (state_q)
			bbc_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = bbc_pkg::S_SEL;
				end
			end
			bbc_pkg::S_SEL: begin
				cmd.select = 1'b1;
				state_d    = bbc_pkg::S_UPD;
			end
			bbc_pkg::S_UPD: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					req_stall  = 1'b0;
					state_d    = req_valid ? bbc_pkg::S_SEL : bbc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bbc_pkg::S_IDLE;
			end
		endcase
		cmd.capture = req_valid && !req_stall;
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bbc_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

[sv/bbc_dp.sv]
module bbc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bbc_pkg::ctrl_cmd_t cmd,
	input  bbc_pkg::req_t      req,
	output bbc_pkg::rsp_t      rsp
);

	localparam int N = bbc_pkg::SLOT_COUNT;

	// Slot state: tags, counts, valid bits and the recency matrix.
	// newer_q[i][j] is set when slot i is more recent than slot j.
	logic [7:0]  dev_q   [N];
	logic [31:0] blk_q   [N];
	logic [7:0]  cnt_q   [N];
	logic        vld_q   [N];
	logic [N-1:0] newer_q [N];

	bbc_pkg::req_t     req_q;
	bbc_pkg::rsp_t     rsp_q, rsp_d;
	bbc_pkg::slot_idx_t tgt_s2;
	logic              hit_s2;
	logic              free_s2;

	logic [N-1:0]       match_vec, free_vec, hit_vec, victim_vec;
	bbc_pkg::slot_idx_t hit_idx, victim_idx;

	logic [7:0] cnt_cur, cnt_new;
	logic       vld_cur, in_range;
	logic       cnt_wr, vld_set, tag_wr, promote;

	// Tag compare across all slots, then pick the most recent match and the
	// least recent free slot from the recency matrix.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			match_vec[i] = (dev_q[i] == req_q.device) && (blk_q[i] == req_q.block_number);
			free_vec[i]  = (cnt_q[i] == 8'd0);
		end
		for (int i = 0; i < N; i++) begin
			hit_vec[i]    = match_vec[i];
			victim_vec[i] = free_vec[i];
			for (int j = 0; j < N; j++) begin
				if (j != i) begin
					if (match_vec[j] && newer_q[j][i]) begin
						hit_vec[i] = 1'b0;
					end
					if (free_vec[j] && newer_q[i][j]) begin
						victim_vec[i] = 1'b0;
					end
				end
			end
		end
		hit_idx    = '0;
		victim_idx = '0;
		for (int i = 0; i < N; i++) begin
			if (hit_vec[i]) begin
				hit_idx = hit_idx | bbc_pkg::slot_idx_t'(i);
			end
			if (victim_vec[i]) begin
				victim_idx = victim_idx | bbc_pkg::slot_idx_t'(i);
			end
		end
	end

	// Request and selection registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.select) begin
			hit_s2  <= |match_vec;
			free_s2 <= |free_vec;
			if (req_q.cmd == bbc_pkg::CMD_GET) begin
				tgt_s2 <= (|match_vec) ? hit_idx : victim_idx;
			end else begin
				tgt_s2 <= bbc_pkg::slot_idx_t'(req_q.slot_in);
			end
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	// Update step: read the chosen slot, form the result and the writes.
	always_comb begin
		cnt_cur  = cnt_q[tgt_s2];
		vld_cur  = vld_q[tgt_s2];
		in_range = int'(req_q.slot_in) < N;
		cnt_new  = cnt_cur;
		cnt_wr   = 1'b0;
		vld_set  = 1'b0;
		tag_wr   = 1'b0;
		promote  = 1'b0;
		rsp_d.slot_out  = req_q.slot_in;
		rsp_d.hit       = 1'b0;
		rsp_d.need_read = 1'b0;
		rsp_d.status    = bbc_pkg::ST_OK;
		case (req_q.cmd)
			bbc_pkg::CMD_GET: begin
				if (hit_s2) begin
					rsp_d.slot_out = 5'(tgt_s2);
					rsp_d.hit      = 1'b1;
					if (cnt_cur == bbc_pkg::COUNT_MAX) begin
						rsp_d.status = bbc_pkg::ST_OVER;
					end else begin
						cnt_new         = cnt_cur + 8'd1;
						cnt_wr          = 1'b1;
						vld_set         = 1'b1;
						rsp_d.need_read = !vld_cur;
					end
				end else if (free_s2) begin
					rsp_d.slot_out  = 5'(tgt_s2);
					rsp_d.need_read = 1'b1;
					cnt_new         = 8'd1;
					cnt_wr          = 1'b1;
					vld_set         = 1'b1;
					tag_wr          = 1'b1;
				end else begin
					rsp_d.slot_out = 5'd0;
					rsp_d.status   = bbc_pkg::ST_NOFREE;
				end
			end
			bbc_pkg::CMD_RELEASE, bbc_pkg::CMD_UNPIN: begin
				if (in_range) begin
					if (cnt_cur == 8'd0) begin
						rsp_d.status = bbc_pkg::ST_UNDER;
					end else begin
						cnt_new = cnt_cur - 8'd1;
						cnt_wr  = 1'b1;
						promote = (req_q.cmd == bbc_pkg::CMD_RELEASE) && (cnt_cur == 8'd1);
					end
				end
			end
			bbc_pkg::CMD_PIN: begin
				if (in_range) begin
					if (cnt_cur == bbc_pkg::COUNT_MAX) begin
						rsp_d.status = bbc_pkg::ST_OVER;
					end else begin
						cnt_new = cnt_cur + 8'd1;
						cnt_wr  = 1'b1;
					end
				end
			end
			default: begin
				rsp_d.status = bbc_pkg::ST_OK;
			end
		endcase
	end

	// Slot state. Reset tags every slot as device 0, block 0, and orders
	// the slots with the highest index most recent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				dev_q[i] <= 8'd0;
				blk_q[i] <= 32'd0;
				cnt_q[i] <= 8'd0;
				vld_q[i] <= 1'b0;
				for (int j = 0; j < N; j++) begin
					newer_q[i][j] <= (i > j);
				end
			end
		end else if (cmd.commit) begin
			if (cnt_wr) begin
				cnt_q[tgt_s2] <= cnt_new;
			end
			if (vld_set) begin
				vld_q[tgt_s2] <= 1'b1;
			end
			if (tag_wr) begin
				dev_q[tgt_s2] <= req_q.device;
				blk_q[tgt_s2] <= req_q.block_number;
			end
			// Moving a slot to most recent: its row sets, its column clears.
			if (promote) begin
				for (int j = 0; j < N; j++) begin
					newer_q[tgt_s2][j] <= (j != int'(tgt_s2));
					if (j != int'(tgt_s2)) begin
						newer_q[j][tgt_s2] <= 1'b0;
					end
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

[sv/bbc_checker.sv]
module bbc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input bbc_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input bbc_pkg::rsp_t rsp
);

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// A response appears from idle only after a request was taken and has gone through the select and update steps.
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
		else $error("response without a request");

	// No free slot reports slot 0 with no hit and no read.
	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bbc_pkg::ST_NOFREE
		|-> rsp.slot_out == 5'd0 && !rsp.hit && !rsp.need_read)
		else $error("bad no-free response");

	// Errors never ask for a disk read.
	a_err_noread: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == bbc_pkg::ST_UNDER || rsp.status == bbc_pkg::ST_OVER)
		|-> !rsp.need_read)
		else $error("error response requests a read");

endmodule

bind block_buffer_cache_lru_refcount_top bbc_checker u_chk (.*);
